// ----- rtl/core/pbf_pkg.sv -----
// shared widths, fixed-point types and limits for the polynomial bond force block
// no dependencies; imported by pbf_mulq and polynomial_bond_force
`default_nettype none

package pbf_pkg;

  localparam int NUM_TYPES_DEF = 8;
  localparam int FRAC_BITS_DEF = 16;

  localparam int SLOTS        = 8;   // r0, k0..k6 per bond type
  localparam int DW           = 32;  // coefficient and separation width
  localparam int QW           = 48;  // result width
  localparam int HW           = QW / 2;
  localparam int HORNER_STEPS = 6;

  typedef logic signed [QW-1:0] q_t;
  typedef logic signed [DW-1:0] d_t;

  localparam q_t Q_MAX = {1'b0, {(QW-1){1'b1}}};
  localparam q_t Q_MIN = {1'b1, {(QW-1){1'b0}}};

endpackage

`default_nettype wire

// ----- rtl/core/pbf_mulq.sv -----
// pipelined fixed-point multiplier lanes: (a*b) >> FRAC_BITS, magnitude truncated, clamped to 48 bits
// three register stages with a tag word carried alongside; depends on pbf_pkg
`default_nettype none

module pbf_mulq #(
  parameter int FRAC_BITS = pbf_pkg::FRAC_BITS_DEF,
  parameter int LANES     = 1,
  parameter int TW        = 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          vin,
  input  pbf_pkg::q_t [LANES-1:0]       a,
  input  pbf_pkg::q_t [LANES-1:0]       b,
  input  logic [TW-1:0]                 tin,
  output logic                          vout,
  output pbf_pkg::q_t [LANES-1:0]       p,
  output logic [LANES-1:0]              psat,
  output logic [TW-1:0]                 tout
);
  import pbf_pkg::*;

  localparam int PW = 2 * QW;

  logic [LANES-1:0][QW-1:0] ma, mb;
  logic [LANES-1:0][QW-1:0] pll, plh, phl, phh;
  logic [LANES-1:0]         neg1, neg2;
  logic [LANES-1:0][PW-1:0] prod2;
  logic [LANES-1:0][PW-1:0] sh, lim;
  logic [LANES-1:0][QW-1:0] mag;
  logic [LANES-1:0]         over;
  logic                     v1, v2;
  logic [TW-1:0]            t1, t2;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      ma[i] = a[i][QW-1] ? QW'(~a[i] + 1'b1) : a[i];
      mb[i] = b[i][QW-1] ? QW'(~b[i] + 1'b1) : b[i];
    end
  end

  // stage 1: four half-width partial products per lane
  always_ff @(posedge clk) begin
    if (en) begin
      t1 <= tin;
      for (int i = 0; i < LANES; i++) begin
        neg1[i] <= a[i][QW-1] ^ b[i][QW-1];
        pll[i]  <= ma[i][HW-1:0] * mb[i][HW-1:0];
        plh[i]  <= ma[i][HW-1:0] * mb[i][QW-1:HW];
        phl[i]  <= ma[i][QW-1:HW] * mb[i][HW-1:0];
        phh[i]  <= ma[i][QW-1:HW] * mb[i][QW-1:HW];
      end
    end
  end

  // stage 2: full product
  always_ff @(posedge clk) begin
    if (en) begin
      t2 <= t1;
      for (int i = 0; i < LANES; i++) begin
        neg2[i]  <= neg1[i];
        prod2[i] <= {phh[i], pll[i]} + (PW'(plh[i]) << HW) + (PW'(phl[i]) << HW);
      end
    end
  end

  // stage 3: scale, clamp, restore sign
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      sh[i]   = prod2[i] >> FRAC_BITS;
      lim[i]  = neg2[i] ? (PW'(1) << (QW - 1)) : ((PW'(1) << (QW - 1)) - PW'(1));
      over[i] = sh[i] > lim[i];
      mag[i]  = over[i] ? lim[i][QW-1:0] : sh[i][QW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tout <= t2;
      for (int i = 0; i < LANES; i++) begin
        p[i]    <= neg2[i] ? QW'(~mag[i] + 1'b1) : mag[i];
        psat[i] <= over[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      vout <= 1'b0;
    end else if (en) begin
      v1   <= vin;
      v2   <= v1;
      vout <= v2;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/polynomial_bond_force.sv -----
// Sixth-order polynomial bond evaluator. A load item (kind 0) writes one
// coefficient word and gives no result; an evaluate item (kind 1) gives one
// result. One item is accepted every cycle while the output side takes
// results; the whole pipeline holds together while a result waits under
// result_stall.
// On the way from an evaluate item to its result (inputs in Q16.16 with
// FRAC_BITS = 16), the root takes one bit per stage over 32 stages, each of
// the six Horner steps takes four stages, and the division by r takes one
// quotient bit per stage over 48 + FRAC_BITS stages. Coefficients are read
// at acceptance, so a load is seen by every evaluate item after it.
// depends on pbf_pkg and pbf_mulq
`default_nettype none

module polynomial_bond_force #(
  parameter int NUM_TYPES = pbf_pkg::NUM_TYPES_DEF,
  parameter int FRAC_BITS = pbf_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        kind,
  input  logic [2:0]  bond_type,
  input  logic [2:0]  coef_slot,
  input  pbf_pkg::d_t coef_value,
  input  pbf_pkg::d_t delta_x,
  input  pbf_pkg::d_t delta_y,
  input  pbf_pkg::d_t delta_z,
  output logic        result_valid,
  input  logic        result_stall,
  output pbf_pkg::q_t bond_energy,
  output pbf_pkg::q_t force_over_r,
  output pbf_pkg::q_t force_x,
  output pbf_pkg::q_t force_y,
  output pbf_pkg::q_t force_z,
  output logic        saturated,
  output logic        zero_length
);
  import pbf_pkg::*;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EVAL = 1'b1;

  localparam int TAW      = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
  localparam int BAW      = (TAW > 3) ? TAW : 3;
  localparam int RW       = DW;
  localparam int VW       = 2 * DW;
  localparam int REMW     = RW + 2;
  localparam int SQ_STEPS = RW;
  localparam int NW       = QW + FRAC_BITS;

  typedef struct packed {
    d_t                       dx, dy, dz;
    logic [SLOTS-1:0][DW-1:0] c;
    logic [VW-1:0]            v;
    logic [REMW-1:0]          rem;
    logic [RW-1:0]            root;
  } sq_t;

  typedef struct packed {
    d_t                              dx, dy, dz;
    logic [RW-1:0]                   root;
    q_t                              dr, e, g;
    logic [HORNER_STEPS-1:0][QW-1:0] ce, cd;
    logic                            sat;
  } hs_t;

  typedef struct packed {
    d_t            dx, dy, dz;
    q_t            e;
    logic          sat, zl, neg;
    logic [RW-1:0] den;
    logic [NW-1:0] n, q;
    logic [RW-1:0] rem;
  } dv_t;

  typedef struct packed {
    d_t   dx, dy, dz;
    q_t   e, fbond;
    logic sat, zl;
  } fb_t;

  function automatic logic [QW:0] add_sat(q_t x, q_t y);
    logic [QW:0] s;
    begin
      s = {x[QW-1], x} + {y[QW-1], y};
      if (s[QW] != s[QW-1]) begin
        add_sat = {1'b1, (s[QW] ? Q_MIN : Q_MAX)};
      end else begin
        add_sat = {1'b0, s[QW-1:0]};
      end
    end
  endfunction

  logic adv, take;
  assign item_stall = result_valid && result_stall;
  assign adv        = !item_stall;
  assign take       = item_valid && !item_stall;

  // coefficient store: one bank per slot, read at acceptance
  logic [BAW-1:0]           bt_ext;
  logic [TAW-1:0]           taddr;
  logic                     type_ok;
  logic [SLOTS-1:0][DW-1:0] crd;

  assign bt_ext  = BAW'(bond_type);
  assign taddr   = bt_ext[TAW-1:0];
  assign type_ok = 32'(bond_type) < NUM_TYPES;

  for (genvar s = 0; s < SLOTS; s++) begin : g_bank
    logic [DW-1:0] mem [NUM_TYPES];
    always_ff @(posedge clk) begin
      if (take && (kind == KIND_LOAD) && type_ok && (32'(coef_slot) == s)) begin
        mem[taddr] <= coef_value;
      end
      if (adv) begin
        crd[s] <= mem[taddr];
      end
    end
  end

  // stage 1: squares of the separation magnitudes
  logic          v1, ok1;
  d_t            dx1, dy1, dz1;
  logic [VW-1:0] sqx1, sqy1, sqz1;
  logic [DW-1:0] mx, my, mz;

  assign mx = delta_x[DW-1] ? DW'(~delta_x + 1'b1) : delta_x;
  assign my = delta_y[DW-1] ? DW'(~delta_y + 1'b1) : delta_y;
  assign mz = delta_z[DW-1] ? DW'(~delta_z + 1'b1) : delta_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= take && (kind == KIND_EVAL);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ok1  <= type_ok;
      dx1  <= delta_x;
      dy1  <= delta_y;
      dz1  <= delta_z;
      sqx1 <= mx * mx;
      sqy1 <= my * my;
      sqz1 <= mz * mz;
    end
  end

  // stage 2 and the root stages
  sq_t                sq  [SQ_STEPS+1];
  logic [SQ_STEPS:0]  sqv;

  always_ff @(posedge clk) begin
    if (rst) begin
      sqv[0] <= 1'b0;
    end else if (adv) begin
      sqv[0] <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq[0].dx   <= dx1;
      sq[0].dy   <= dy1;
      sq[0].dz   <= dz1;
      sq[0].c    <= ok1 ? crd : '0;
      sq[0].v    <= sqx1 + sqy1 + sqz1;
      sq[0].rem  <= '0;
      sq[0].root <= '0;
    end
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    logic [REMW+1:0] rs, trial;
    sq_t             nx;
    always_comb begin
      nx    = sq[k];
      rs    = {sq[k].rem, sq[k].v[VW-1 -: 2]};
      trial = (REMW+2)'({sq[k].root, 2'b01});
      nx.v  = sq[k].v << 2;
      if (rs >= trial) begin
        nx.rem  = REMW'(rs - trial);
        nx.root = {sq[k].root[RW-2:0], 1'b1};
      end else begin
        nx.rem  = REMW'(rs);
        nx.root = {sq[k].root[RW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        sqv[k+1] <= 1'b0;
      end else if (adv) begin
        sqv[k+1] <= sqv[k];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sq[k+1] <= nx;
      end
    end
  end

  // dr stage: offset from r0, coefficient sets for both Horner chains
  hs_t                   hs  [HORNER_STEPS+1];
  logic [HORNER_STEPS:0] hsv;
  hs_t                   hs0;

  always_comb begin
    hs0.dx   = sq[SQ_STEPS].dx;
    hs0.dy   = sq[SQ_STEPS].dy;
    hs0.dz   = sq[SQ_STEPS].dz;
    hs0.root = sq[SQ_STEPS].root;
    hs0.dr   = q_t'($signed({1'b0, sq[SQ_STEPS].root})) -
               q_t'($signed(sq[SQ_STEPS].c[0]));
    hs0.e    = q_t'($signed(sq[SQ_STEPS].c[SLOTS-1]));
    hs0.g    = '0;
    hs0.sat  = 1'b0;
    for (int j = 0; j < HORNER_STEPS; j++) begin
      hs0.ce[j] = q_t'($signed(sq[SQ_STEPS].c[SLOTS-2-j]));
      hs0.cd[j] = QW'(q_t'($signed(sq[SQ_STEPS].c[SLOTS-1-j])) * q_t'(HORNER_STEPS - j));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hsv[0] <= 1'b0;
    end else if (adv) begin
      hsv[0] <= sqv[SQ_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hs[0] <= hs0;
    end
  end

  // Horner steps, energy and derivative side by side
  for (genvar j = 0; j < HORNER_STEPS; j++) begin : g_horner
    q_t [1:0]                 ma, mb, mp;
    logic [1:0]               ms;
    logic                     mv;
    logic [$bits(hs_t)-1:0]   mt;
    hs_t                      ht, nx;
    logic [QW:0]              se, sg;

    assign ma[0] = hs[j].dr;
    assign ma[1] = hs[j].dr;
    assign mb[0] = hs[j].e;
    assign mb[1] = hs[j].g;

    pbf_mulq #(
      .FRAC_BITS (FRAC_BITS),
      .LANES     (2),
      .TW        ($bits(hs_t))
    ) u_mul (
      .clk  (clk),
      .rst  (rst),
      .en   (adv),
      .vin  (hsv[j]),
      .a    (ma),
      .b    (mb),
      .tin  (hs[j]),
      .vout (mv),
      .p    (mp),
      .psat (ms),
      .tout (mt)
    );

    always_comb begin
      ht     = mt;
      se     = add_sat(ht.ce[j], mp[0]);
      sg     = add_sat(ht.cd[j], mp[1]);
      nx     = ht;
      nx.e   = se[QW-1:0];
      nx.g   = sg[QW-1:0];
      nx.sat = ht.sat | (|ms) | se[QW] | sg[QW];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        hsv[j+1] <= 1'b0;
      end else if (adv) begin
        hsv[j+1] <= mv;
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        hs[j+1] <= nx;
      end
    end
  end

  // division of -g by r, one quotient bit per stage
  dv_t           dv  [NW+1];
  logic [NW:0]   dvv;
  dv_t           dv0;
  logic [QW-1:0] gmag;

  always_comb begin
    gmag    = hs[HORNER_STEPS].g[QW-1] ? QW'(~hs[HORNER_STEPS].g + 1'b1)
                                       : hs[HORNER_STEPS].g;
    dv0.dx  = hs[HORNER_STEPS].dx;
    dv0.dy  = hs[HORNER_STEPS].dy;
    dv0.dz  = hs[HORNER_STEPS].dz;
    dv0.e   = hs[HORNER_STEPS].e;
    dv0.sat = hs[HORNER_STEPS].sat;
    dv0.zl  = hs[HORNER_STEPS].root == '0;
    dv0.neg = !hs[HORNER_STEPS].g[QW-1] && (hs[HORNER_STEPS].g != '0);
    dv0.den = hs[HORNER_STEPS].root;
    dv0.n   = NW'(gmag) << FRAC_BITS;
    dv0.q   = '0;
    dv0.rem = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dvv[0] <= 1'b0;
    end else if (adv) begin
      dvv[0] <= hsv[HORNER_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv[0] <= dv0;
    end
  end

  for (genvar k = 0; k < NW; k++) begin : g_div
    logic [RW:0] rs;
    dv_t         nx;
    always_comb begin
      nx   = dv[k];
      rs   = {dv[k].rem, dv[k].n[NW-1]};
      nx.n = dv[k].n << 1;
      if (rs >= {1'b0, dv[k].den}) begin
        nx.rem = RW'(rs - {1'b0, dv[k].den});
        nx.q   = {dv[k].q[NW-2:0], 1'b1};
      end else begin
        nx.rem = rs[RW-1:0];
        nx.q   = {dv[k].q[NW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dvv[k+1] <= 1'b0;
      end else if (adv) begin
        dvv[k+1] <= dvv[k];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dv[k+1] <= nx;
      end
    end
  end

  // force over r: clamp the quotient, zero when r is zero
  fb_t           fb, fb_next;
  logic          fbv;
  logic [NW-1:0] qlim;
  logic          qover;
  logic [QW-1:0] qmag;

  always_comb begin
    qlim  = dv[NW].neg ? (NW'(1) << (QW - 1)) : ((NW'(1) << (QW - 1)) - NW'(1));
    qover = dv[NW].q > qlim;
    qmag  = qover ? qlim[QW-1:0] : dv[NW].q[QW-1:0];
    fb_next.dx  = dv[NW].dx;
    fb_next.dy  = dv[NW].dy;
    fb_next.dz  = dv[NW].dz;
    fb_next.e   = dv[NW].e;
    fb_next.zl  = dv[NW].zl;
    fb_next.sat = dv[NW].sat | (qover & !dv[NW].zl);
    if (dv[NW].zl) begin
      fb_next.fbond = '0;
    end else begin
      fb_next.fbond = dv[NW].neg ? QW'(~qmag + 1'b1) : qmag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fbv <= 1'b0;
    end else if (adv) begin
      fbv <= dvv[NW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fb <= fb_next;
    end
  end

  // force vector
  q_t [2:0]               fa, fbb, fp;
  logic [2:0]             fs;
  logic                   fv;
  logic [$bits(fb_t)-1:0] ftag;
  fb_t                    fo;

  assign fa[0]  = q_t'(fb.dx);
  assign fa[1]  = q_t'(fb.dy);
  assign fa[2]  = q_t'(fb.dz);
  assign fbb[0] = fb.fbond;
  assign fbb[1] = fb.fbond;
  assign fbb[2] = fb.fbond;

  pbf_mulq #(
    .FRAC_BITS (FRAC_BITS),
    .LANES     (3),
    .TW        ($bits(fb_t))
  ) u_force (
    .clk  (clk),
    .rst  (rst),
    .en   (adv),
    .vin  (fbv),
    .a    (fa),
    .b    (fbb),
    .tin  (fb),
    .vout (fv),
    .p    (fp),
    .psat (fs),
    .tout (ftag)
  );

  assign fo = ftag;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= fv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bond_energy  <= fo.e;
      force_over_r <= fo.fbond;
      force_x      <= fo.zl ? '0 : fp[0];
      force_y      <= fo.zl ? '0 : fp[1];
      force_z      <= fo.zl ? '0 : fp[2];
      saturated    <= fo.sat | ((|fs) & !fo.zl);
      zero_length  <= fo.zl;
    end
  end

endmodule

`default_nettype wire
